### sv/bounded_priority_queue_core_defines.svh
// Assertion helpers for the checker file.
`ifndef BOUNDED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Concurrent check, masked while reset is asserted.
`define BPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define BPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bpq_pkg.sv
package bpq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int VAL_W     = 32;
  localparam int PRI_W     = 8;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } cell_ctl_t;

endpackage

### sv/bpq_cell.sv
module bpq_cell (
  input  logic               clk,
  input  bpq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_lt,
  input  bpq_pkg::entry_t    left_ent,
  input  bpq_pkg::entry_t    right_ent,
  output bpq_pkg::entry_t    ent,
  output logic               lt
);
  import bpq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // Entries stay sorted by priority, descending, oldest first among equals.
  assign lt  = !occ || (ent_r.prio < ctl.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins && lt) begin
      if (left_lt) begin
        ent_nxt = left_ent;
      end else begin
        ent_nxt.value = ctl.value;
        ent_nxt.prio  = ctl.prio;
      end
    end else if (ctl.rem) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

### sv/bounded_priority_queue_core.sv
// Channel | Direction | tdata (low bit up)                 | tuser
// in_     | slave     | value[31:0], priority_req[39:32]   | op[1:0]
// out_    | master    | removed_value[31:0]                | status[1:0]
//
// For every transaction the DEPTH cells update in parallel; on an insert each
// decides its move from its own priority compare and its left neighbor's.
// A new transaction is taken every cycle while the output register is free
// or being drained; a stalled output holds input off.
// Synchronous active-low reset empties the queue and drops any pending result.
module bounded_priority_queue_core #(
  parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], priority_req[39:32]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // removed_value[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import bpq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]       out_stat_r, out_stat_nxt;

  cell_ctl_t        ctl;
  entry_t           ent_w [DEPTH];
  logic             lt_w  [DEPTH];
  logic             in_fire;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_lt;
    entry_t left_ent;
    entry_t right_ent;

    assign occ = (CntW'(i) < cnt_r);

    if (i == 0) begin : g_head
      assign left_lt  = 1'b0;
      assign left_ent = ent_w[0];
    end else begin : g_body
      assign left_lt  = lt_w[i-1];
      assign left_ent = ent_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = ent_w[i];
    end else begin : g_mid
      assign right_ent = ent_w[i+1];
    end

    bpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_lt   (left_lt),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ent_w[i]),
      .lt        (lt_w[i])
    );
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    ctl.ins       = 1'b0;
    ctl.rem       = 1'b0;
    ctl.value     = in_tdata[31:0];
    ctl.prio      = in_tdata[39:32];
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_stat_nxt  = ST_OK;
      case (in_tuser)
        OP_CLEAR: begin
          cnt_nxt = '0;
        end
        OP_INSERT: begin
          if (cnt_r == CntW'(DEPTH)) begin
            out_stat_nxt = ST_OVERFLOW;
          end else begin
            ctl.ins = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (cnt_r == '0) begin
            out_stat_nxt = ST_UNDERFLOW;
          end else begin
            // Head holds the winner; shift everything one cell toward it.
            ctl.rem      = 1'b1;
            out_data_nxt = ent_w[0].value;
            cnt_nxt      = cnt_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule

### sv/bpq_checker.sv
`include "bounded_priority_queue_core_defines.svh"

module bpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,   // value[31:0], priority_req[39:32]
  input logic [1:0]  in_tuser,   // op[1:0]
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,  // removed_value[31:0]
  input logic [1:0]  out_tuser   // status[1:0]
);
  import bpq_pkg::*;

  logic in_fire;
  logic in_pay_seen;

  assign in_fire     = in_tvalid && in_tready;
  assign in_pay_seen = ^in_tdata || !(^in_tdata);

  `BPQ_ASSERT_ALWAYS(a_reset_drops_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `BPQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `BPQ_ASSERT(a_accept_gives_result, in_fire && in_pay_seen |=> out_tvalid, "accepted transaction gave no result")
  `BPQ_ASSERT(a_error_zero, out_tvalid && out_tuser != ST_OK |-> out_tdata == '0, "error status with nonzero value")
  `BPQ_ASSERT(a_clear_then_remove, (in_fire && in_tuser == OP_CLEAR) ##1 (in_fire && in_tuser == OP_REMOVE) |=> out_tuser == ST_UNDERFLOW, "remove after clear did not underflow")

endmodule

bind bounded_priority_queue_core bpq_checker u_bpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bpq_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEF;
  // Op code 3 is not assigned: the block answers it like a no-op.
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int HOLD_CYCLES = 40;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES = 13;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
  } answer_t;

  class pq_scoreboard;
    logic [VAL_W-1:0] slot_value [QUEUE_DEPTH];
    logic [PRI_W-1:0] slot_prio [QUEUE_DEPTH];
    int unsigned fill = 0;
    int unsigned failures = 0;
    answer_t pending_answers[$];

    // Advance the queue model by one accepted transaction.
    function void note_request(logic [1:0] op, logic [VAL_W-1:0] value,
                               logic [PRI_W-1:0] prio);
      answer_t ans;
      int unsigned best;
      ans.value = '0;
      ans.status = ST_OK;
      case (op)
        OP_CLEAR: begin
          fill = 0;
        end
        OP_INSERT: begin
          if (fill >= QUEUE_DEPTH) begin
            ans.status = ST_OVERFLOW;
          end else begin
            slot_value[fill] = value;
            slot_prio[fill] = prio;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (fill == 0) begin
            ans.status = ST_UNDERFLOW;
          end else begin
            // Strict compare keeps the earliest entry on a priority tie.
            best = 0;
            for (int i = 1; i < fill; i++)
              if (slot_prio[i] > slot_prio[best]) best = i;
            ans.value = slot_value[best];
            for (int i = best; i + 1 < fill; i++) begin
              slot_value[i] = slot_value[i + 1];
              slot_prio[i] = slot_prio[i + 1];
            end
            fill--;
          end
        end
        default: ;
      endcase
      pending_answers.push_back(ans);
    endfunction

    function void check_response(logic [VAL_W-1:0] value, logic [1:0] status);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: value %h status %0d", $time, value, status);
        failures++;
        return;
      end
      want = pending_answers.pop_front();
      if (value !== want.value) begin
        $display("%0t: removed_value mismatch: expected %h actual %h",
                 $time, want.value, value);
        failures++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  logic hold_req = 1'b0;
  logic no_gaps = 1'b0;

  pq_scoreboard sb;

  bounded_priority_queue_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send(input logic [1:0] op, input logic [VAL_W-1:0] value,
                      input logic [PRI_W-1:0] prio);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {prio, value};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, value, prio);
  endtask

  task automatic send_random(input int unsigned insert_pct);
    int unsigned r;
    logic [1:0] op;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
    r = $urandom_range(0, 99);
    if (r < 3) op = OP_CLEAR;
    else if (r < 6) op = OP_NOP;
    else if (r < 6 + insert_pct) op = OP_INSERT;
    else op = OP_REMOVE;
    value = $urandom;
    // Narrow priorities often, so ties are common.
    prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                       : 8'($urandom_range(0, 255));
    send(op, value, prio);
  endtask

  // Pause the sender until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_answers.size() != 0);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req <= 1'b0;
      end else begin
        n = pick_gap();
      end
      if (n == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata, out_tuser);
  end

  initial begin
    #5000000;
    $display("FAIL bounded_priority_queue_core");
    $finish;
  end

  initial begin
    int unsigned insert_mix [NUM_PHASES];
    insert_mix = '{50, 70, 60, 30, 45, 55, 80, 20, 47, 65, 40, 52, 48};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_REMOVE, 32'h1234_5678, 8'hFF);  // underflow on empty queue
    send(OP_NOP,    32'hFFFF_FFFF, 8'hFF);
    send(OP_INSERT, 32'h8000_0000, 8'h00);
    send(OP_INSERT, 32'h7FFF_FFFF, 8'hFF);
    send(OP_INSERT, 32'hFFFF_FFFF, 8'hFF);  // ties with the previous entry
    send(OP_INSERT, 32'h0000_0000, 8'h80);
    send(OP_INSERT, 32'h5555_5555, 8'h7F);
    send(OP_INSERT, 32'hAAAA_AAAA, 8'h80);
    send(OP_INSERT, 32'h0000_0001, 8'h01);
    send(OP_INSERT, 32'hDEAD_BEEF, 8'h00);  // queue now full
    send(OP_INSERT, 32'h0BAD_F00D, 8'hFF);  // overflow, dropped
    send(OP_REMOVE, 32'hFFFF_FFFF, 8'h00);
    send(OP_REMOVE, 32'h0000_0000, 8'hFF);
    send(OP_REMOVE, 32'hA5A5_A5A5, 8'h5A);
    send(OP_CLEAR,  32'hFFFF_FFFF, 8'hFF);
    send(OP_REMOVE, 32'h0000_0000, 8'h00);  // underflow after clear
    send(OP_INSERT, 32'hCAFE_0000, 8'h10);
    send(OP_INSERT, 32'h0000_CAFE, 8'h10);
    send(OP_REMOVE, 32'h0000_0000, 8'h00);
    send(OP_REMOVE, 32'h0000_0000, 8'h00);
    send(OP_NOP,    32'h0000_0000, 8'h00);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        // Stall the result side while the sender streams back to back.
        hold_req <= 1'b1;
        no_gaps <= 1'b1;
      end else if (p == 5) begin
        no_gaps <= 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) send_random(insert_mix[p]);
      no_gaps <= 1'b0;
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending_answers.size() == 0) begin
      $display("PASS bounded_priority_queue_core");
    end else begin
      $display("FAIL bounded_priority_queue_core");
    end
    $finish;
  end

endmodule
